// ----- design/tcc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Text console cursor: shared types and constants
// Character codes, register indexes, the register file record and the
// queue entry that passes from the front end to the back end.
// ============================================================================
`default_nettype none

package tcc_pkg;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_TAB       = 8'd9;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_SPACE     = 8'd32;

    // Largest pixel position a 12-bit coordinate can hold.
    localparam logic [11:0] POS_MAX = 12'd4095;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BASE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_WIDTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_HEIGHT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TAB_WIDTH     = 3'd5;

    // Register reset values.
    localparam logic [63:0] RST_FRAME_BASE    = 64'hFFFF_8000_00A0_0000;
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd1440;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd900;
    localparam logic [5:0]  RST_CELL_WIDTH    = 6'd8;
    localparam logic [5:0]  RST_CELL_HEIGHT   = 6'd16;
    localparam logic [11:0] RST_TAB_WIDTH     = 12'd64;

    typedef struct packed {
        logic [63:0] frame_base;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [5:0]  cell_width;
        logic [5:0]  cell_height;
        logic [11:0] tab_width;
    } cfg_t;

    // Operation class decided by the front end.
    typedef enum logic [1:0] {
        OP_PRINT     = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_TAB       = 2'd2,
        OP_NEWLINE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  code;
        logic [31:0] fg;
        logic [31:0] bg;
    } q_entry_t;

    // Handshake between the back end and the tab stop unit.
    typedef struct packed {
        logic start;
        logic ack;
    } tab_ctrl_t;

    typedef struct packed {
        logic        idle;
        logic        done;
        logic [11:0] rem;
    } tab_stat_t;

    // One draw request as it moves down the back end pipeline.
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  glyph;
        logic [31:0] fg;
        logic [31:0] bg;
    } draw_t;

endpackage

`default_nettype wire

// ----- design/tcc_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Text console cursor: front end
// Accepts one character transaction per cycle into an input register while
// the command queue has room, classifies the code and pushes the entry there.
// ============================================================================
`default_nettype none

module tcc_front
    import tcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic [31:0] fore_colour,
    input  wire logic [31:0] back_colour,
    output logic             push,
    output q_entry_t         push_data,
    input  wire logic        full
);

    logic     valid_reg;
    logic     valid_next;
    q_entry_t entry_reg;
    logic     accept;
    op_t      op_class;

    // The input register holds until the queue has room.
    assign in_stall = valid_reg && full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !full;
    assign push_data = entry_reg;

    // Sort the character into its operation class.
    always_comb
    begin
        case (char_code)
            CODE_BACKSPACE: op_class = OP_BACKSPACE;
            CODE_TAB:       op_class = OP_TAB;
            CODE_NEWLINE:   op_class = OP_NEWLINE;
            default:        op_class = OP_PRINT;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= '{op: op_class, code: char_code, fg: fore_colour, bg: back_colour};
        end
    end

endmodule

`default_nettype wire

// ----- design/tcc_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Text console cursor: command queue
// Short first-in first-out buffer between the front end and the back end,
// so that each side can stall without holding the other.
// ============================================================================
`default_nettype none

module tcc_queue
    import tcc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_data,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output q_entry_t      head_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    q_entry_t        mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/tcc_tab_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Text console cursor: tab stop unit
// Finds the cursor position modulo the tab width by restoring division,
// one quotient bit per cycle, so the next tab stop is x - rem + width.
// ============================================================================
`default_nettype none

module tcc_tab_unit
    import tcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tab_ctrl_t   ctrl,
    input  wire logic [11:0] dividend,
    input  wire logic [11:0] divisor,
    output tab_stat_t        stat
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_DONE = 3'b100
    } tab_state_t;

    tab_state_t  state_reg;
    tab_state_t  state_next;
    logic [3:0]  bit_reg;
    logic [3:0]  bit_next;
    logic [11:0] rem_reg;
    logic [11:0] rem_next;
    logic [12:0] trial;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    assign trial = {rem_reg, dividend[bit_reg]};

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_BUSY;
                    bit_next   = 4'd11;
                    rem_next   = '0;
                end
            end
            ST_BUSY:
            begin
                if (trial >= {1'b0, divisor})
                begin
                    rem_next = 12'(trial - {1'b0, divisor});
                end
                else
                begin
                    rem_next = trial[11:0];
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 4'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign stat = '{idle: (state_reg == ST_IDLE), done: (state_reg == ST_DONE), rem: rem_reg};

endmodule

`default_nettype wire

// ----- design/tcc_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Text console cursor: back end
// Pops classified commands, keeps the pixel cursor, and sends draw requests
// through a multiply stage and an address stage to the output register.
// ============================================================================
`default_nettype none

module tcc_back
    import tcc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire logic         head_valid,
    input  wire q_entry_t     head_data,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [11:0]       cell_x,
    output logic [11:0]       cell_y,
    output logic [63:0]       pixel_address,
    output logic [7:0]        glyph,
    output logic [31:0]       draw_fore,
    output logic [31:0]       draw_back
);

    logic [11:0] cursor_x_reg;
    logic [11:0] cursor_x_next;
    logic [11:0] cursor_y_reg;
    logic [11:0] cursor_y_next;

    logic        e_valid_reg;
    draw_t       e_draw_reg;
    logic        m_valid_reg;
    draw_t       m_draw_reg;
    logic [23:0] m_prod_reg;
    logic        o_valid_reg;
    draw_t       o_draw_reg;
    logic [63:0] o_addr_reg;

    logic        adv;
    logic        emit;
    draw_t       emit_draw;
    logic [11:0] tab_div;
    logic [11:0] y_step;
    logic [12:0] tab_stop;
    logic [12:0] x_sum;
    logic [11:0] x_print;
    logic [11:0] y_print;
    logic [24:0] offset;

    tab_ctrl_t   tab_ctrl;
    tab_stat_t   tab_stat;

    // Next text row, wrapping to the top when it would pass the bottom.
    function automatic logic [11:0] line_step(input logic [11:0] y, input logic [5:0] ch,
                                              input logic [11:0] sh);
        logic [12:0] n;
        n = {1'b0, y} + {7'b0, ch};
        return (n >= {1'b0, sh}) ? 12'd0 : n[11:0];
    endfunction

    // The whole pipeline moves unless a finished result is held at the output.
    assign adv = !(o_valid_reg && out_stall);

    assign tab_div = (cfg.tab_width == '0) ? 12'd1 : cfg.tab_width;

    // A tab waits for the remainder unit; other commands leave as soon as the pipeline moves.
    assign pop = head_valid && adv && ((head_data.op != OP_TAB) || tab_stat.done);
    assign tab_ctrl.start = head_valid && (head_data.op == OP_TAB) && tab_stat.idle;
    assign tab_ctrl.ack   = pop && (head_data.op == OP_TAB);

    tcc_tab_unit u_tab_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (tab_ctrl),
        .dividend (cursor_x_reg),
        .divisor  (tab_div),
        .stat     (tab_stat)
    );

    assign y_step   = line_step(cursor_y_reg, cfg.cell_height, cfg.screen_height);
    assign tab_stop = {1'b0, cursor_x_reg} - {1'b0, tab_stat.rem} + {1'b0, tab_div};

    // A printable first wraps the row when the cursor sits past the right edge.
    assign x_print = (cursor_x_reg >= cfg.screen_width) ? 12'd0 : cursor_x_reg;
    assign y_print = (cursor_x_reg >= cfg.screen_width) ? y_step : cursor_y_reg;
    assign x_sum   = {1'b0, x_print} + {7'b0, cfg.cell_width};

    // Cursor update and draw request for the command at the queue head.
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        emit          = 1'b0;
        emit_draw     = '{x: x_print, y: y_print, glyph: head_data.code,
                          fg: head_data.fg, bg: head_data.bg};
        case (head_data.op)
            OP_BACKSPACE:
            begin
                if (cursor_x_reg >= {6'b0, cfg.cell_width})
                begin
                    cursor_x_next = cursor_x_reg - {6'b0, cfg.cell_width};
                end
                else if (cursor_y_reg != '0)
                begin
                    cursor_y_next = (cursor_y_reg >= {6'b0, cfg.cell_height}) ?
                                    cursor_y_reg - {6'b0, cfg.cell_height} : 12'd0;
                    cursor_x_next = (cfg.screen_width >= {6'b0, cfg.cell_width}) ?
                                    cfg.screen_width - {6'b0, cfg.cell_width} : 12'd0;
                end
                emit = 1'b1;
                emit_draw.x     = cursor_x_next;
                emit_draw.y     = cursor_y_next;
                emit_draw.glyph = CODE_SPACE;
            end
            OP_NEWLINE:
            begin
                cursor_x_next = '0;
                cursor_y_next = y_step;
            end
            OP_TAB:
            begin
                if (tab_stop >= {1'b0, cfg.screen_width})
                begin
                    cursor_x_next = '0;
                    cursor_y_next = y_step;
                end
                else
                begin
                    cursor_x_next = tab_stop[11:0];
                end
            end
            default:
            begin
                emit          = 1'b1;
                cursor_y_next = y_print;
                cursor_x_next = x_sum[12] ? POS_MAX : x_sum[11:0];
            end
        endcase
    end

    assign offset = {1'b0, m_prod_reg} + {13'b0, m_draw_reg.x};

    // Control state of the cursor and the pipeline stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            e_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
            if (adv)
            begin
                e_valid_reg <= pop && emit;
                m_valid_reg <= e_valid_reg;
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    // Payload stages: row multiply, then the byte address.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_draw_reg <= emit_draw;
            m_draw_reg <= e_draw_reg;
            m_prod_reg <= e_draw_reg.y * cfg.screen_width;
            o_draw_reg <= m_draw_reg;
            o_addr_reg <= cfg.frame_base + {37'b0, offset, 2'b00};
        end
    end

    assign out_valid     = o_valid_reg;
    assign cell_x        = o_draw_reg.x;
    assign cell_y        = o_draw_reg.y;
    assign pixel_address = o_addr_reg;
    assign glyph         = o_draw_reg.glyph;
    assign draw_fore     = o_draw_reg.fg;
    assign draw_back     = o_draw_reg.bg;

    // The cursor moves only when a command leaves the queue.
    a_cursor_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> $stable(cursor_x_reg) && $stable(cursor_y_reg))
        else $error("cursor moved without a command");

    // A tab never creates a draw request.
    a_tab_silent : assert property (@(posedge clk) disable iff (!rst_n)
        pop && (head_data.op == OP_TAB) |=> !e_valid_reg)
        else $error("tab produced a draw request");

    // A backspace always requests a space.
    a_backspace_draw : assert property (@(posedge clk) disable iff (!rst_n)
        pop && (head_data.op == OP_BACKSPACE) |=> e_valid_reg && (e_draw_reg.glyph == CODE_SPACE))
        else $error("backspace did not request a space");

endmodule

`default_nettype wire

// ----- design/text_console_cursor.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Text console cursor
// Tracks a pixel cursor over a character stream and issues cell draw
// requests with framebuffer addresses for a text console.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid/in_stall    char_code, fore_colour, back_colour
//  output    out        out_valid/out_stall  cell_x, cell_y, pixel_address, glyph,
//                                            draw_fore, draw_back
//  config    in         cfg_we               cfg_index, cfg_data
//
//  Printable, backspace and newline characters leave the back end while it is
//  not stalled; a tab holds it until the 12-step remainder unit has finished.
//  A draw request passes input, queue, emit, multiply and output registers.
//  Reset clears the cursor to the top-left and loads the register defaults.
//  The command queue absorbs output stalls, so input keeps flowing until it fills.
//
`default_nettype none

module text_console_cursor
    import tcc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]            cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             char_code,
    input  wire logic [31:0]            fore_colour,
    input  wire logic [31:0]            back_colour,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [11:0]                 cell_x,
    output logic [11:0]                 cell_y,
    output logic [63:0]                 pixel_address,
    output logic [7:0]                  glyph,
    output logic [31:0]                 draw_fore,
    output logic [31:0]                 draw_back
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     push;
    q_entry_t push_data;
    logic     full;
    logic     pop;
    logic     head_valid;
    q_entry_t head_data;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_BASE:    cfg_next.frame_base    = cfg_data;
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[11:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[11:0];
                REG_CELL_WIDTH:    cfg_next.cell_width    = cfg_data[5:0];
                REG_CELL_HEIGHT:   cfg_next.cell_height   = cfg_data[5:0];
                REG_TAB_WIDTH:     cfg_next.tab_width     = cfg_data[11:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{frame_base: RST_FRAME_BASE, screen_width: RST_SCREEN_WIDTH,
                         screen_height: RST_SCREEN_HEIGHT, cell_width: RST_CELL_WIDTH,
                         cell_height: RST_CELL_HEIGHT, tab_width: RST_TAB_WIDTH};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .fore_colour (fore_colour),
        .back_colour (back_colour),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    tcc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .pixel_address (pixel_address),
        .glyph         (glyph),
        .draw_fore     (draw_fore),
        .draw_back     (draw_back)
    );

endmodule

`default_nettype wire

// ----- verif/text_console_cursor_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Text console cursor testbench
// Drives character transactions into the cursor block and checks every cell
// draw request against a cursor predictor held in a small scoreboard. Runs a
// directed pass over the wrap and backspace corner cases, then random phases
// under several register settings with bursty input and output stalls.
// ============================================================================

module text_console_cursor_test;

    import tcc_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 128;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned PHASE_ITEMS   = 160;

    // One cell draw request as seen on the output channel.
    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [63:0] addr;
        logic [7:0]  glyph;
        logic [31:0] fore;
        logic [31:0] back;
    } cell_draw_t;

    // Cursor predictor plus the queue of draw requests still owed by the block.
    class draw_scoreboard;
        logic [63:0] frame_base;
        int unsigned screen_w;
        int unsigned screen_h;
        int unsigned cell_w;
        int unsigned cell_h;
        int unsigned tab_w;
        int unsigned cur_x;
        int unsigned cur_y;
        cell_draw_t  owed_draws[$];
        int unsigned errors;

        function new();
            frame_base = RST_FRAME_BASE;
            screen_w   = RST_SCREEN_WIDTH;
            screen_h   = RST_SCREEN_HEIGHT;
            cell_w     = RST_CELL_WIDTH;
            cell_h     = RST_CELL_HEIGHT;
            tab_w      = RST_TAB_WIDTH;
            cur_x      = 0;
            cur_y      = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [63:0] value);
            case (index)
                REG_FRAME_BASE:    frame_base = value;
                REG_SCREEN_WIDTH:  screen_w   = value[11:0];
                REG_SCREEN_HEIGHT: screen_h   = value[11:0];
                REG_CELL_WIDTH:    cell_w     = value[5:0];
                REG_CELL_HEIGHT:   cell_h     = value[5:0];
                REG_TAB_WIDTH:     tab_w      = value[11:0];
                default: ;
            endcase
        endfunction

        function int unsigned next_row(int unsigned y);
            int unsigned n;
            n = y + cell_h;
            return (n >= screen_h) ? 0 : n;
        endfunction

        function void owe_draw(logic [7:0] glyph, logic [31:0] fore, logic [31:0] back);
            cell_draw_t  d;
            logic [63:0] offset;
            offset  = 64'(cur_y) * 64'(screen_w) + 64'(cur_x);
            d.x     = cur_x[11:0];
            d.y     = cur_y[11:0];
            d.addr  = frame_base + (offset << 2);
            d.glyph = glyph;
            d.fore  = fore;
            d.back  = back;
            owed_draws.push_back(d);
        endfunction

        // Moves the cursor for one accepted character and records any draw it causes.
        function void note_char(logic [7:0] code, logic [31:0] fore, logic [31:0] back);
            int unsigned stop;
            int unsigned nx;
            if (code == CODE_BACKSPACE) begin
                if (cur_x >= cell_w) begin
                    cur_x = cur_x - cell_w;
                end
                else if (cur_y > 0) begin
                    cur_y = (cur_y >= cell_h) ? cur_y - cell_h : 0;
                    cur_x = (screen_w >= cell_w) ? screen_w - cell_w : 0;
                end
                owe_draw(CODE_SPACE, fore, back);
            end
            else if (code == CODE_NEWLINE) begin
                cur_y = next_row(cur_y);
                cur_x = 0;
            end
            else if (code == CODE_TAB) begin
                stop = (tab_w == 0) ? 1 : tab_w;
                nx   = (cur_x / stop + 1) * stop;
                if (nx >= screen_w) begin
                    cur_x = 0;
                    cur_y = next_row(cur_y);
                end
                else begin
                    cur_x = nx;
                end
            end
            else begin
                if (cur_x >= screen_w) begin
                    cur_x = 0;
                    cur_y = next_row(cur_y);
                end
                owe_draw(code, fore, back);
                nx    = cur_x + cell_w;
                cur_x = (nx > POS_MAX) ? POS_MAX : nx;
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_draw(cell_draw_t got);
            cell_draw_t want;
            if (owed_draws.size() == 0) begin
                $display("%0t: unexpected draw, expected none, actual x=%0d y=%0d glyph=%0h",
                         $time, got.x, got.y, got.glyph);
                errors++;
                return;
            end
            want = owed_draws.pop_front();
            compare_field("cell_x", 64'(want.x), 64'(got.x));
            compare_field("cell_y", 64'(want.y), 64'(got.y));
            compare_field("pixel_address", want.addr, got.addr);
            compare_field("glyph", 64'(want.glyph), 64'(got.glyph));
            compare_field("draw_fore", 64'(want.fore), 64'(got.fore));
            compare_field("draw_back", 64'(want.back), 64'(got.back));
        endfunction

        function int unsigned pending();
            return owed_draws.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             char_code = '0;
    logic [31:0]            fore_colour = '0;
    logic [31:0]            back_colour = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [11:0]            cell_x;
    logic [11:0]            cell_y;
    logic [63:0]            pixel_address;
    logic [7:0]             glyph;
    logic [31:0]            draw_fore;
    logic [31:0]            draw_back;

    bit             hold_request = 1'b0;
    draw_scoreboard board = new();

    text_console_cursor DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .fore_colour   (fore_colour),
        .back_colour   (back_colour),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .pixel_address (pixel_address),
        .glyph         (glyph),
        .draw_fore     (draw_fore),
        .draw_back     (draw_back)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog for a hung run.
    initial
    begin
        #4_000_000;
        $display("text_console_cursor_test NOT OK");
        $finish;
    end

    // Output side: check each accepted transaction, then choose the next stall.
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned stall_mode;
        int unsigned cycle;
        cell_draw_t  got;
        hold_left  = 0;
        stall_mode = 0;
        cycle      = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (out_valid && !out_stall) begin
                got.x     = cell_x;
                got.y     = cell_y;
                got.addr  = pixel_address;
                got.glyph = glyph;
                got.fore  = draw_fore;
                got.back  = draw_back;
                board.check_draw(got);
            end
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_stall   <= 1'b1;
            end
            else begin
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((cycle % 7) < 3);
                endcase
            end
        end
    end

    // Offers one character transaction and holds it until the block takes it.
    task automatic send_char(input logic [7:0] code, input logic [31:0] fore,
                             input logic [31:0] back);
        in_valid    <= 1'b1;
        char_code   <= code;
        fore_colour <= fore;
        back_colour <= back;
        do
            @(posedge clk);
        while (in_stall);
        board.note_char(code, fore, back);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        board.set_reg(index, value);
    endtask

    // Fills the bits above a register's width with noise; the block must ignore them.
    function automatic logic [63:0] padded(int unsigned value, int unsigned width);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return ((noise >> width) << width) | 64'(value);
    endfunction

    task automatic load_config(input logic [63:0] base, input int unsigned sw,
                               input int unsigned sh, input int unsigned cw,
                               input int unsigned ch, input int unsigned tw);
        write_reg(REG_FRAME_BASE, base);
        write_reg(REG_SCREEN_WIDTH, padded(sw, 12));
        write_reg(REG_SCREEN_HEIGHT, padded(sh, 12));
        write_reg(REG_CELL_WIDTH, padded(cw, 6));
        write_reg(REG_CELL_HEIGHT, padded(ch, 6));
        write_reg(REG_TAB_WIDTH, padded(tw, 12));
        cfg_we <= 1'b0;
    endtask

    // Stops sending, waits for every owed draw, then lets queued tabs and newlines finish.
    task automatic quiesce();
        int unsigned waited;
        in_valid <= 1'b0;
        for (waited = 0; board.pending() != 0 && waited < DRAIN_LIMIT; waited++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_code();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return CODE_BACKSPACE;
        else if (pick < 20)
            return CODE_TAB;
        else if (pick < 30)
            return CODE_NEWLINE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] random_colour();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic random_phase(input int unsigned phase);
        int unsigned burst;
        int unsigned gap;
        int unsigned i;
        case (phase)
            0: load_config({$urandom, $urandom}, 1440, 900, 8, 16, 64);
            1: load_config('1, 4095, 4095, 63, 63, 4095);
            2: load_config('0, 1, 1, 1, 1, 1);
            3: load_config({$urandom, $urandom}, 40, 64, 8, 16, 16);
            4: load_config(64'hFFFF_FFFF_FFFF_0000, 4095, 4095, 63, 1, 0);
            default: load_config({$urandom, $urandom}, $urandom_range(1, 4095),
                                 $urandom_range(1, 4095), $urandom_range(1, 63),
                                 $urandom_range(1, 63),
                                 ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                                             : $urandom_range(1, 200));
        endcase
        burst = 0;
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 40);
            end
            burst--;
            // Long output hold-off so the internal queue fills and backs up the input.
            if (i == 60 && (phase == 1 || phase == 5))
                hold_request = 1'b1;
            send_char(random_code(), random_colour(), random_colour());
        end
        quiesce();
    endtask

    // Stimulus: directed corner cases, then random phases.
    initial
    begin : stimulus
        int unsigned phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: byte extremes, backspaces back to the origin, tab, newline, row back-step.
        send_char(8'h00, 32'h1234_5678, 32'h9ABC_DEF0);
        send_char(8'hFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_char(CODE_BACKSPACE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_char(CODE_BACKSPACE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_char(CODE_TAB, 32'h0, 32'h0);
        send_char(CODE_NEWLINE, 32'h0, 32'h0);
        send_char(CODE_BACKSPACE, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        send_char("A", 32'h0000_00FF, 32'h0000_FF00);
        quiesce();

        // Narrow screen: row wrap on print, zero tab width, bottom wrap on newline.
        load_config('0, 20, 40, 8, 16, 0);
        send_char("a", 32'h1, 32'h2);
        send_char("b", 32'h3, 32'h4);
        send_char("c", 32'h5, 32'h6);
        send_char("d", 32'h7, 32'h8);
        send_char(CODE_TAB, 32'h0, 32'h0);
        send_char(CODE_NEWLINE, 32'h0, 32'h0);
        send_char(CODE_NEWLINE, 32'h0, 32'h0);
        send_char(CODE_NEWLINE, 32'h0, 32'h0);
        quiesce();

        // Cursor sits above a partial row and the cell is wider than the screen.
        load_config(64'h0000_0000_1000_0000, 4, 40, 8, 63, 8);
        send_char(CODE_BACKSPACE, 32'hDEAD_BEEF, 32'hCAFE_F00D);
        quiesce();

        // Largest screen: advance saturates at the last column, next print wraps.
        load_config('1, 4095, 4095, 63, 63, 4090);
        send_char(CODE_TAB, 32'h0, 32'h0);
        send_char("X", 32'h8000_0000, 32'h0000_0001);
        send_char("Y", 32'h7FFF_FFFF, 32'hFFFF_FFFE);
        send_char(CODE_BACKSPACE, 32'h1111_1111, 32'h2222_2222);
        quiesce();

        for (phase = 0; phase < PHASE_COUNT; phase++)
            random_phase(phase);

        if (board.pending() != 0) begin
            $display("%0t: draws still owed, expected 0, actual %0d", $time, board.pending());
            board.errors += board.pending();
        end
        if (board.errors == 0)
            $display("text_console_cursor_test OK");
        else
            $display("text_console_cursor_test NOT OK");
        $finish;
    end

endmodule
